>>> design/epoch_seeded_index_shuffle_core_macros.svh
// Assertion macros shared by the shuffle core checker.
// No dependencies; included by bare file name.
`ifndef EPOCH_SEEDED_INDEX_SHUFFLE_CORE_MACROS_SVH
`define EPOCH_SEEDED_INDEX_SHUFFLE_CORE_MACROS_SVH

// same-cycle implication, disabled while reset is high
`define ESIS_ASSERT_IMP(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("esis assertion failed");

// next-cycle implication, disabled while reset is high
`define ESIS_ASSERT_NXT(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("esis assertion failed");

`endif

>>> design/esis_pkg.sv
// Shared types, constants and helper functions for the epoch shuffle core.
// No dependencies; used by the core and the remainder unit.
package esis_pkg;

  localparam int MAX_ITEMS_DEF = 64;
  localparam int GEN_W         = 32;
  localparam int CFG_W         = 7;
  localparam int OUT_W         = 6;

  localparam logic [GEN_W-1:0] SEED_BASE = 32'd34972;
  localparam logic [GEN_W-1:0] SEED_MULT = 32'h9E37_79B9;
  localparam logic [CFG_W-1:0] ITEM_COUNT_RESET = 7'd64;

  localparam int SH_A = 13;
  localparam int SH_B = 17;
  localparam int SH_C = 5;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_SEED,
    ST_FILL,
    ST_ADV,
    ST_MOD,
    ST_RD_J,
    ST_WR_HI,
    ST_WR_J,
    ST_EMIT
  } state_t;

  typedef struct packed {
    logic             start;
    logic [GEN_W-1:0] dividend;
  } mod_ctrl_t;

  // one xorshift32 step
  function automatic logic [GEN_W-1:0] advance(input logic [GEN_W-1:0] x);
    logic [GEN_W-1:0] y;
    y = x ^ (x << SH_A);
    y = y ^ (y >> SH_B);
    y = y ^ (y << SH_C);
    return y;
  endfunction

endpackage

>>> design/esis_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module esis_ram #(
  parameter int WIDTH = 6,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

>>> design/esis_mod_unit.sv
// Bit-serial remainder unit: dividend mod divisor, one dividend bit per cycle.
// Depends on esis_pkg.
module esis_mod_unit #(
  parameter int CNT_W = 7
) (
  input  logic                clk,
  input  logic                rst,
  input  esis_pkg::mod_ctrl_t ctrl,
  input  logic [CNT_W-1:0]    divisor,
  output logic                done,
  output logic [CNT_W-1:0]    remainder
);

  localparam int BIT_W = $clog2(esis_pkg::GEN_W);

  logic                      busy;
  logic [esis_pkg::GEN_W-1:0] dq;
  logic [BIT_W-1:0]          cnt;
  logic [CNT_W:0]            trial;
  logic [CNT_W-1:0]          remainder_next;

  always_comb begin
    trial = {remainder, dq[esis_pkg::GEN_W-1]};
    if (trial >= {1'b0, divisor}) begin
      remainder_next = CNT_W'(trial - {1'b0, divisor});
    end else begin
      remainder_next = trial[CNT_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (ctrl.start) begin
        dq        <= ctrl.dividend;
        remainder <= '0;
        cnt       <= '0;
        busy      <= 1'b1;
      end else if (busy) begin
        dq        <= dq << 1;
        remainder <= remainder_next;
        cnt       <= cnt + BIT_W'(1);
        if (cnt == BIT_W'(esis_pkg::GEN_W - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

endmodule

>>> design/epoch_seeded_index_shuffle_core.sv
// Epoch-seeded index shuffle. An accepted epoch seeds xorshift32, the core fills its index
// store with 0..n-1, runs a Fisher-Yates pass from the top entry down, then streams the n
// indices out on consecutive cycles with strobe high, last_of_run on the final one. The
// receiver cannot stall, so results go out back to back. Each swap step runs the
// bit-serial remainder unit, then reads entry j and makes two writes to the index store.
// busy is high from the cycle after start until the last word has been issued.
module epoch_seeded_index_shuffle_core #(
  parameter int MAX_ITEMS = esis_pkg::MAX_ITEMS_DEF
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          start,
  output logic                          busy,
  input  logic [esis_pkg::GEN_W-1:0]    epoch_number,
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic [esis_pkg::CFG_W-1:0]    item_count,
  output logic                          strobe,
  output logic [esis_pkg::OUT_W-1:0]    sample_index,
  output logic                          last_of_run
);

  localparam int IDX_W = $clog2(MAX_ITEMS);
  localparam int CNT_W = $clog2(MAX_ITEMS + 1);
  localparam int GW    = esis_pkg::GEN_W;

  esis_pkg::state_t state, state_next;

  logic [esis_pkg::CFG_W-1:0] item_count_q;
  logic [GW-1:0]              ep_q;
  logic [GW-1:0]              gen;
  logic [CNT_W-1:0]           n_q;
  logic [CNT_W-1:0]           k;
  logic [CNT_W-1:0]           i_q;
  logic [IDX_W-1:0]           j_q;
  logic [IDX_W-1:0]           t_q;
  logic                       emit_q;
  logic                       last_q;

  logic [CNT_W-1:0]           cnt_eff;
  logic [CNT_W-1:0]           n_m1;
  logic [CNT_W-1:0]           i_m1;
  logic [GW-1:0]              seed_raw;
  logic [GW-1:0]              seed;
  logic                       k_last;

  logic                       we;
  logic [IDX_W-1:0]           waddr;
  logic [IDX_W-1:0]           wdata;
  logic                       re;
  logic [IDX_W-1:0]           raddr;
  logic [IDX_W-1:0]           rdata;

  esis_pkg::mod_ctrl_t        mod_ctrl;
  logic                       mod_done;
  logic [CNT_W-1:0]           mod_rem;

  assign cnt_eff = (item_count_q > esis_pkg::CFG_W'(MAX_ITEMS)) ?
                   CNT_W'(MAX_ITEMS) : item_count_q[CNT_W-1:0];
  assign n_m1    = n_q - CNT_W'(1);
  assign i_m1    = i_q - CNT_W'(1);
  assign k_last  = (k == n_m1);
  assign seed_raw = esis_pkg::SEED_BASE ^ GW'(ep_q * esis_pkg::SEED_MULT);
  assign seed     = (seed_raw == '0) ? GW'(1) : seed_raw;

  // next state
  always_comb begin
    state_next = state;
    case (state)
      esis_pkg::ST_IDLE:  if (start) state_next = esis_pkg::ST_SEED;
      esis_pkg::ST_SEED: begin
        state_next = (n_q == '0) ? esis_pkg::ST_IDLE : esis_pkg::ST_FILL;
      end
      esis_pkg::ST_FILL: begin
        if (k_last) begin
          state_next = (n_q == CNT_W'(1)) ? esis_pkg::ST_EMIT : esis_pkg::ST_ADV;
        end
      end
      esis_pkg::ST_ADV:   state_next = esis_pkg::ST_MOD;
      esis_pkg::ST_MOD:   if (mod_done) state_next = esis_pkg::ST_RD_J;
      esis_pkg::ST_RD_J:  state_next = esis_pkg::ST_WR_HI;
      esis_pkg::ST_WR_HI: state_next = esis_pkg::ST_WR_J;
      esis_pkg::ST_WR_J: begin
        state_next = (i_q == CNT_W'(2)) ? esis_pkg::ST_EMIT : esis_pkg::ST_ADV;
      end
      esis_pkg::ST_EMIT:  if (k_last) state_next = esis_pkg::ST_IDLE;
      default:            state_next = esis_pkg::ST_IDLE;
    endcase
  end

  // store, remainder unit and handshake controls
  always_comb begin
    we                = 1'b0;
    waddr             = k[IDX_W-1:0];
    wdata             = k[IDX_W-1:0];
    re                = 1'b0;
    raddr             = k[IDX_W-1:0];
    mod_ctrl.start    = 1'b0;
    mod_ctrl.dividend = esis_pkg::advance(gen);
    busy              = (state != esis_pkg::ST_IDLE);
    cfg_ready         = (state == esis_pkg::ST_IDLE);
    case (state)
      esis_pkg::ST_FILL: we = 1'b1;
      esis_pkg::ST_ADV:  mod_ctrl.start = 1'b1;
      esis_pkg::ST_MOD: begin
        re    = mod_done;
        raddr = i_m1[IDX_W-1:0];
      end
      esis_pkg::ST_RD_J: begin
        re    = 1'b1;
        raddr = j_q;
      end
      esis_pkg::ST_WR_HI: begin
        we    = 1'b1;
        waddr = i_m1[IDX_W-1:0];
        wdata = rdata;
      end
      esis_pkg::ST_WR_J: begin
        we    = 1'b1;
        waddr = j_q;
        wdata = t_q;
      end
      esis_pkg::ST_EMIT: re = 1'b1;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= esis_pkg::ST_IDLE;
      item_count_q <= esis_pkg::ITEM_COUNT_RESET;
      gen          <= GW'(1);
      emit_q       <= 1'b0;
      last_q       <= 1'b0;
    end else begin
      state  <= state_next;
      emit_q <= (state == esis_pkg::ST_EMIT);
      last_q <= (state == esis_pkg::ST_EMIT) && k_last;
      if (cfg_valid && cfg_ready) begin
        item_count_q <= item_count;
      end
      case (state)
        esis_pkg::ST_IDLE: begin
          if (start) begin
            ep_q <= epoch_number + GW'(1);
            n_q  <= cnt_eff;
          end
        end
        esis_pkg::ST_SEED: begin
          if (n_q != '0) gen <= seed;
          k <= '0;
        end
        esis_pkg::ST_FILL: begin
          k <= k + CNT_W'(1);
          if (k_last) begin
            k   <= '0;
            i_q <= n_q;
          end
        end
        esis_pkg::ST_ADV:  gen <= esis_pkg::advance(gen);
        esis_pkg::ST_MOD:  if (mod_done) j_q <= mod_rem[IDX_W-1:0];
        esis_pkg::ST_RD_J: t_q <= rdata;
        esis_pkg::ST_WR_J: i_q <= i_m1;
        esis_pkg::ST_EMIT: k <= k + CNT_W'(1);
        default: ;
      endcase
    end
  end

  esis_ram #(
    .WIDTH(IDX_W),
    .DEPTH(MAX_ITEMS)
  ) u_store (
    .clk  (clk),
    .we   (we),
    .waddr(waddr),
    .wdata(wdata),
    .re   (re),
    .raddr(raddr),
    .rdata(rdata)
  );

  esis_mod_unit #(
    .CNT_W(CNT_W)
  ) u_mod (
    .clk      (clk),
    .rst      (rst),
    .ctrl     (mod_ctrl),
    .divisor  (i_q),
    .done     (mod_done),
    .remainder(mod_rem)
  );

  assign strobe       = emit_q;
  assign last_of_run  = last_q;
  assign sample_index = esis_pkg::OUT_W'(rdata);

endmodule

>>> design/esis_checker.sv
// Port-level checker for the epoch shuffle core, bound to the top level.
// Depends on epoch_seeded_index_shuffle_core_macros.svh.
`include "epoch_seeded_index_shuffle_core_macros.svh"

module esis_checker (
  input logic clk,
  input logic rst,
  input logic start,
  input logic busy,
  input logic strobe,
  input logic last_of_run
);

  // every word is issued while the core is working on an epoch
  `ESIS_ASSERT_IMP(a_strobe_in_run, clk, rst, strobe, $past(busy))
  // an accepted epoch makes the core busy on the next cycle
  `ESIS_ASSERT_NXT(a_start_busy, clk, rst, start && !busy, busy)
  // words of one run come out on consecutive cycles
  `ESIS_ASSERT_NXT(a_run_contig, clk, rst, strobe && !last_of_run, strobe)
  // nothing follows the final word directly
  `ESIS_ASSERT_NXT(a_last_ends, clk, rst, strobe && last_of_run, !strobe)

endmodule

bind epoch_seeded_index_shuffle_core esis_checker u_esis_checker (
  .clk        (clk),
  .rst        (rst),
  .start      (start),
  .busy       (busy),
  .strobe     (strobe),
  .last_of_run(last_of_run)
);
